>>> sv/kbs_pkg.sv
// Shared types and constants of the k-nomial broadcast scheduler.
// Used by every module of the block; depends on nothing.
package kbs_pkg;

  localparam int MAX_RANKS = 1024;
  localparam int MAX_RADIX = 16;
  localparam int RANK_W    = 10;
  localparam int SIZE_W    = 11;
  localparam int RADIX_W   = 5;
  localparam int DIG_W     = 4;
  localparam int PROD_W    = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;

  localparam logic       OP_BEGIN = 1'b0;
  localparam logic       OP_COMPL = 1'b1;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] REG_MY_RANK = 2'd0;
  localparam logic [1:0] REG_N_RANKS = 2'd1;
  localparam logic [1:0] REG_RADIX   = 2'd2;

  typedef struct packed {
    logic              op;
    logic [RANK_W-1:0] root_rank;
    logic [DATA_W-1:0] msg_length;
    logic [DATA_W-1:0] msg_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [RANK_W-1:0] peer_rank;
    logic [DATA_W-1:0] length_out;
    logic [DATA_W-1:0] tag_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  my_rank;
    logic [SIZE_W-1:0]  n_ranks;
    logic [RADIX_W-1:0] radix;
  } cfg_t;

  typedef enum logic [2:0] {
    DV_ROOT, DV_ME, DV_VR_DIST, DV_Q_ER, DV_PEER, DV_DIST_ER
  } dsel_t;

  typedef enum logic [1:0] {
    M_ER, M_ER_LESS1, M_POS
  } msel_t;

  typedef enum logic [4:0] {
    A_NONE, A_START, A_ROOT, A_ME, A_VR, A_DSTEP, A_LEVEL, A_VD, A_POS,
    A_SINIT, A_SSTEP, A_RINIT, A_PEER, A_EMIT_SEND, A_EMIT_RECV,
    A_EMIT_DONE, A_NEXT
  } act_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_ROOT_DIV, S_ME_DIV, S_VR, S_DLOOP, S_LEVEL,
    S_VD_DIV, S_POS_DIV, S_SINIT, S_SEND_CHK, S_SPEER_DIV, S_EMIT_S,
    S_RINIT, S_RPEER_DIV, S_EMIT_R, S_NEXT_DIV, S_FIN
  } state_t;

  typedef struct packed {
    logic  div_start;
    dsel_t div_sel;
    msel_t mul_sel;
    act_t  act;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic div_rem_zero;
    logic gs_one;
    logic dist_zero;
    logic dstep_ok;
    logic vpeer_in;
    logic idx_zero;
    logic sent;
    logic out_free;
  } sts_t;

endpackage

>>> sv/kbs_div.sv
// Restoring divider, one quotient bit per cycle, for the scheduler datapath.
// Depends on kbs_pkg for widths.
module kbs_div
  import kbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [SIZE_W-1:0] quot,
  output logic [SIZE_W-1:0] rem
);

  localparam int CNT_W = $clog2(SIZE_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   trial;

  assign shifted = {rem, quot[SIZE_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SIZE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[SIZE_W]) begin
        rem  <= trial[SIZE_W-1:0];
        quot <= {quot[SIZE_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[SIZE_W-1:0];
        quot <= {quot[SIZE_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/kbs_datapath.sv
// Datapath: saved broadcast state, level arithmetic, shared divider and result register.
// Depends on kbs_pkg and kbs_div; driven by kbs_ctrl commands.
module kbs_datapath
  import kbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [RANK_W-1:0]  root_s;
  logic [RANK_W-1:0]  vr;
  logic [RADIX_W-1:0] er;
  logic [SIZE_W-1:0]  lvl_dist;
  logic [DATA_W-1:0]  len_s;
  logic [DATA_W-1:0]  tag_s;
  logic [SIZE_W-1:0]  qreg;
  logic [DIG_W-1:0]   pos;
  logic [PROD_W-1:0]  vpeer;
  logic [DIG_W-1:0]   idx;
  logic               sent;
  logic [RANK_W-1:0]  peer;

  logic [SIZE_W-1:0]  gs;
  logic [RADIX_W-1:0] er_start;
  logic [RADIX_W-1:0] mfac;
  logic [PROD_W-1:0]  prod;
  logic [SIZE_W+1:0]  vsum;
  logic [SIZE_W-1:0]  dv_a;
  logic [SIZE_W-1:0]  dv_b;
  logic               dv_busy;
  logic               dv_done;
  logic [SIZE_W-1:0]  dv_q;
  logic [SIZE_W-1:0]  dv_r;
  logic               out_free;

  // Live group size, clamped to 1..MAX_RANKS.
  always_comb begin
    gs = cfg.n_ranks;
    if (gs == '0) gs = SIZE_W'(1);
    if (gs > SIZE_W'(MAX_RANKS)) gs = SIZE_W'(MAX_RANKS);
  end

  always_comb begin
    er_start = cfg.radix;
    if (er_start < RADIX_W'(2)) er_start = RADIX_W'(2);
    if (er_start > RADIX_W'(MAX_RADIX)) er_start = RADIX_W'(MAX_RADIX);
    if (SIZE_W'(er_start) > gs) er_start = gs[RADIX_W-1:0];
  end

  // One shared multiplier: er*dist, (er-1)*dist or pos*dist.
  always_comb begin
    case (cmd.mul_sel)
      M_ER:    mfac = er;
      M_POS:   mfac = RADIX_W'(pos);
      default: mfac = er - RADIX_W'(1);
    endcase
    prod = PROD_W'(mfac) * PROD_W'(lvl_dist);
  end

  assign vsum = (SIZE_W+2)'(vr) + (SIZE_W+2)'(gs) - (SIZE_W+2)'(root_s);

  always_comb begin
    case (cmd.div_sel)
      DV_ROOT:    begin dv_a = SIZE_W'(root_s);      dv_b = gs;             end
      DV_ME:      begin dv_a = SIZE_W'(cfg.my_rank); dv_b = gs;             end
      DV_VR_DIST: begin dv_a = SIZE_W'(vr);          dv_b = lvl_dist;       end
      DV_Q_ER:    begin dv_a = qreg;                 dv_b = SIZE_W'(er);    end
      DV_PEER: begin
        dv_a = SIZE_W'(vpeer[RANK_W-1:0]) + SIZE_W'(root_s);
        dv_b = gs;
      end
      DV_DIST_ER: begin dv_a = lvl_dist;             dv_b = SIZE_W'(er);    end
      default:    begin dv_a = SIZE_W'(vr);          dv_b = gs;             end
    endcase
  end

  kbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .busy     (dv_busy),
    .done     (dv_done),
    .quot     (dv_q),
    .rem      (dv_r)
  );

  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.div_busy     = dv_busy;
    sts.div_done     = dv_done;
    sts.div_rem_zero = (dv_r == '0);
    sts.gs_one       = (gs == SIZE_W'(1));
    sts.dist_zero    = (lvl_dist == '0);
    sts.dstep_ok     = (prod < PROD_W'(gs));
    sts.vpeer_in     = (vpeer < PROD_W'(gs));
    sts.idx_zero     = (idx == '0);
    sts.sent         = sent;
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent     <= 1'b0;
      lvl_dist <= '0;
      er       <= RADIX_W'(4);
    end else begin
      case (cmd.act)
        A_START:     er <= er_start;
        A_VR:        lvl_dist <= SIZE_W'(1);
        A_DSTEP:     lvl_dist <= prod[SIZE_W-1:0];
        A_LEVEL:     sent <= 1'b0;
        A_EMIT_SEND: sent <= 1'b1;
        A_EMIT_RECV: sent <= 1'b1;
        A_NEXT:      lvl_dist <= dv_q;
        A_EMIT_DONE: lvl_dist <= '0;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      A_START: begin
        root_s <= in_item.root_rank;
        len_s  <= in_item.msg_length;
        tag_s  <= in_item.msg_tag;
      end
      A_ROOT: root_s <= dv_r[RANK_W-1:0];
      A_ME:   vr <= dv_r[RANK_W-1:0];
      A_VR: begin
        if (vsum >= (SIZE_W+2)'(gs)) vr <= RANK_W'(vsum - (SIZE_W+2)'(gs));
        else vr <= vsum[RANK_W-1:0];
      end
      A_VD:  qreg <= dv_q;
      A_POS: pos <= dv_r[DIG_W-1:0];
      A_SINIT: begin
        idx   <= DIG_W'(er - RADIX_W'(1));
        vpeer <= PROD_W'(vr) + prod;
      end
      A_SSTEP, A_EMIT_SEND: begin
        idx   <= idx - DIG_W'(1);
        vpeer <= vpeer - PROD_W'(lvl_dist);
      end
      A_RINIT: vpeer <= PROD_W'(vr) - prod;
      A_PEER:  peer <= dv_r[RANK_W-1:0];
      default: ;
    endcase
  end

  // Result register: load on emit, drop after transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.act == A_EMIT_SEND || cmd.act == A_EMIT_RECV ||
                 cmd.act == A_EMIT_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      A_EMIT_SEND: out_item <= '{KIND_SEND, peer, len_s, tag_s, idx == DIG_W'(1)};
      A_EMIT_RECV: out_item <= '{KIND_RECV, peer, len_s, tag_s, 1'b1};
      A_EMIT_DONE: out_item <= '{KIND_DONE, '0, len_s, tag_s, 1'b1};
      default:     ;
    endcase
  end

endmodule

>>> sv/kbs_ctrl.sv
// Controller state machine: sequences start setup, level walk and command emission.
// Depends on kbs_pkg; talks to kbs_datapath through cmd_t and sts_t.
module kbs_ctrl
  import kbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   fire;
  logic   div_state;

  assign in_ready = (state == S_IDLE) || (state == S_WAIT);
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_WAIT: begin
        if (fire && in_op == OP_BEGIN) begin
          state_next = sts.gs_one ? S_FIN : S_ROOT_DIV;
        end else if (fire && state == S_WAIT) begin
          state_next = S_LEVEL;
        end
      end
      S_ROOT_DIV:  if (sts.div_done) state_next = S_ME_DIV;
      S_ME_DIV:    if (sts.div_done) state_next = S_VR;
      S_VR:        state_next = S_DLOOP;
      S_DLOOP:     if (!sts.dstep_ok) state_next = S_LEVEL;
      S_LEVEL:     state_next = sts.dist_zero ? S_FIN : S_VD_DIV;
      S_VD_DIV: begin
        if (sts.div_done) state_next = sts.div_rem_zero ? S_POS_DIV : S_NEXT_DIV;
      end
      S_POS_DIV: begin
        if (sts.div_done) state_next = sts.div_rem_zero ? S_SINIT : S_RINIT;
      end
      S_SINIT: state_next = S_SEND_CHK;
      S_SEND_CHK: begin
        if (sts.idx_zero) state_next = S_NEXT_DIV;
        else if (sts.vpeer_in) state_next = S_SPEER_DIV;
      end
      S_SPEER_DIV: if (sts.div_done) state_next = S_EMIT_S;
      S_EMIT_S:    if (sts.out_free) state_next = S_SEND_CHK;
      S_RINIT:     state_next = S_RPEER_DIV;
      S_RPEER_DIV: if (sts.div_done) state_next = S_EMIT_R;
      S_EMIT_R:    if (sts.out_free) state_next = S_NEXT_DIV;
      S_NEXT_DIV:  if (sts.div_done) state_next = sts.sent ? S_WAIT : S_LEVEL;
      S_FIN:       if (sts.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_state   = 1'b0;
    cmd.div_sel = DV_ROOT;
    cmd.mul_sel = M_ER_LESS1;
    cmd.act     = A_NONE;
    case (state)
      S_IDLE, S_WAIT: if (fire && in_op == OP_BEGIN) cmd.act = A_START;
      S_ROOT_DIV: begin
        div_state = 1'b1;
        if (sts.div_done) cmd.act = A_ROOT;
      end
      S_ME_DIV: begin
        div_state   = 1'b1;
        cmd.div_sel = DV_ME;
        if (sts.div_done) cmd.act = A_ME;
      end
      S_VR:    cmd.act = A_VR;
      S_DLOOP: begin
        cmd.mul_sel = M_ER;
        if (sts.dstep_ok) cmd.act = A_DSTEP;
      end
      S_LEVEL: cmd.act = A_LEVEL;
      S_VD_DIV: begin
        div_state   = 1'b1;
        cmd.div_sel = DV_VR_DIST;
        if (sts.div_done) cmd.act = A_VD;
      end
      S_POS_DIV: begin
        div_state   = 1'b1;
        cmd.div_sel = DV_Q_ER;
        if (sts.div_done) cmd.act = A_POS;
      end
      S_SINIT: cmd.act = A_SINIT;
      S_SEND_CHK: if (!sts.idx_zero && !sts.vpeer_in) cmd.act = A_SSTEP;
      S_SPEER_DIV, S_RPEER_DIV: begin
        div_state   = 1'b1;
        cmd.div_sel = DV_PEER;
        if (sts.div_done) cmd.act = A_PEER;
      end
      S_EMIT_S: if (sts.out_free) cmd.act = A_EMIT_SEND;
      S_RINIT: begin
        cmd.mul_sel = M_POS;
        cmd.act     = A_RINIT;
      end
      S_EMIT_R: if (sts.out_free) cmd.act = A_EMIT_RECV;
      S_NEXT_DIV: begin
        div_state   = 1'b1;
        cmd.div_sel = DV_DIST_ER;
        if (sts.div_done) cmd.act = A_NEXT;
      end
      S_FIN:   if (sts.out_free) cmd.act = A_EMIT_DONE;
      default: ;
    endcase
    // Launch once per divide state; done marks the cycle the result is ready.
    cmd.div_start = div_state && !sts.div_busy && !sts.div_done;
  end

endmodule

>>> sv/knomial_broadcast_scheduler.sv
// K-nomial tree broadcast scheduler. Modulo and quotient steps, but for the virtual-rank
// wrap, use one shared 11-bit restoring divider. A start costs two divides plus the radix
// steps; each level costs two or three divides, and each send or receive one more divide
// plus a check or setup state and an emit state. A step with no level left (group of one
// included) goes straight to the done item; emits wait on out_ready. One item at a time.
// Synchronous active-high reset: idle, my_rank 0, rank count 1, radix 4, no result pending.
module knomial_broadcast_scheduler
  import kbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_rank <= '0;
      cfg.n_ranks <= SIZE_W'(1);
      cfg.radix   <= RADIX_W'(4);
    end else if (wr) begin
      case (paddr[3:2])
        REG_MY_RANK: cfg.my_rank <= pwdata[RANK_W-1:0];
        REG_N_RANKS: cfg.n_ranks <= pwdata[SIZE_W-1:0];
        REG_RADIX:   cfg.radix   <= pwdata[RADIX_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MY_RANK: prdata = DATA_W'(cfg.my_rank);
      REG_N_RANKS: prdata = DATA_W'(cfg.n_ranks);
      REG_RADIX:   prdata = DATA_W'(cfg.radix);
      default:     prdata = '0;
    endcase
  end

  kbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kbs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> !in_ready) else $error("input taken during divide");

  a_div_launch: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> sts.div_busy) else $error("divider did not launch");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.act == A_EMIT_SEND || cmd.act == A_EMIT_RECV ||
                                    cmd.act == A_EMIT_DONE))
    else $error("result overwritten");

endmodule

>>> test/kbs_checker.sv
// Checker for the k-nomial broadcast scheduler: watches the configuration port and both
// item channels, predicts the command stream and compares each output transfer.
// Depends on kbs_pkg.
module kbs_checker
  import kbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                errors,
  output int                pending
);

  // register copies
  logic [RANK_W-1:0]  cfg_rank;
  logic [SIZE_W-1:0]  cfg_size;
  logic [RADIX_W-1:0] cfg_radix;

  // broadcast state
  logic              bc_busy;
  int unsigned       bc_dist;
  int unsigned       bc_vrank;
  int unsigned       bc_root;
  logic [DATA_W-1:0] bc_len;
  logic [DATA_W-1:0] bc_tag;
  int unsigned       bc_radix;

  out_item_t expected_cmds[$];

  assign pending = expected_cmds.size();

  function automatic int unsigned group_now();
    int unsigned g;
    g = cfg_size;
    if (g == 0) g = 1;
    if (g > MAX_RANKS) g = MAX_RANKS;
    return g;
  endfunction

  task automatic push_cmd(logic [1:0] kind, int unsigned peer, logic fin);
    out_item_t c;
    c.kind       = kind;
    c.peer_rank  = peer[RANK_W-1:0];
    c.length_out = bc_len;
    c.tag_out    = bc_tag;
    c.last       = fin;
    expected_cmds.push_back(c);
  endtask

  task automatic finish_bcast();
    push_cmd(KIND_DONE, 0, 1'b1);
    bc_busy = 1'b0;
    bc_dist = 0;
  endtask

  // Walk levels down from the saved distance; stop after the first level that issues commands.
  task automatic walk_levels();
    int unsigned gs, er, vr, lvl_dist, pos, vpeer;
    int n, i;
    gs       = group_now();
    er       = bc_radix;
    vr       = bc_vrank;
    lvl_dist = bc_dist;
    while (lvl_dist >= 1) begin
      n = 0;
      if (er >= 2 && (vr % lvl_dist) == 0) begin
        pos = (vr / lvl_dist) % er;
        if (pos == 0) begin
          for (i = er - 1; i >= 1; i--) begin
            vpeer = vr + i * lvl_dist;
            if (vpeer < gs) begin
              push_cmd(KIND_SEND, (vpeer + bc_root) % gs, 1'b0);
              n++;
            end
          end
        end else begin
          push_cmd(KIND_RECV, ((vr - pos * lvl_dist) + bc_root) % gs, 1'b0);
          n++;
        end
      end
      lvl_dist = (er >= 2) ? lvl_dist / er : 0;
      if (n > 0) begin
        expected_cmds[expected_cmds.size() - 1].last = 1'b1;
        bc_dist = lvl_dist;
        bc_busy = 1'b1;
        return;
      end
    end
    finish_bcast();
  endtask

  task automatic predict(in_item_t it);
    int unsigned gs, r, root, me, d;
    if (it.op == OP_BEGIN) begin
      gs = group_now();
      r  = cfg_radix;
      if (r < 2) r = 2;
      if (r > MAX_RADIX) r = MAX_RADIX;
      if (r > gs) r = gs;
      root     = it.root_rank % gs;
      me       = cfg_rank % gs;
      bc_root  = root;
      bc_len   = it.msg_length;
      bc_tag   = it.msg_tag;
      bc_radix = r;
      bc_vrank = (me + gs - root) % gs;
      if (gs == 1) begin
        finish_bcast();
      end else begin
        d = 1;
        while (d * r < gs) d = d * r;
        bc_dist = d;
        bc_busy = 1'b1;
        walk_levels();
      end
    end else if (bc_busy) begin
      walk_levels();
    end
  endtask

  task automatic compare_cmd(out_item_t got);
    out_item_t want;
    if (expected_cmds.size() == 0) begin
      errors++;
      if (errors <= 10) $display("command mismatch: expected nothing, got %p", got);
    end else begin
      want = expected_cmds.pop_front();
      if (got.kind !== want.kind || got.peer_rank !== want.peer_rank ||
          got.length_out !== want.length_out || got.tag_out !== want.tag_out ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) $display("command mismatch: expected %p, got %p", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_rank  <= '0;
      cfg_size  <= SIZE_W'(1);
      cfg_radix <= RADIX_W'(4);
      bc_busy   = 1'b0;
      bc_dist   = 0;
      bc_vrank  = 0;
      bc_root   = 0;
      bc_len    = '0;
      bc_tag    = '0;
      bc_radix  = 4;
      errors    = 0;
      expected_cmds.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MY_RANK: cfg_rank  <= pwdata[RANK_W-1:0];
          REG_N_RANKS: cfg_size  <= pwdata[SIZE_W-1:0];
          REG_RADIX:   cfg_radix <= pwdata[RADIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict(in_item);
      if (out_valid && out_ready) compare_cmd(out_item);
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for the k-nomial broadcast scheduler: drives configuration and start /
// completion items with random gaps and stalls; checking is done in kbs_checker.
// Depends on kbs_pkg, kbs_checker and knomial_broadcast_scheduler.
module tb;
  import kbs_pkg::*;

  localparam int DRAIN = 400;
  localparam int LIMIT = 2000000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                n_accepted;
  int                n_random;
  int                cycles;
  logic              gaps_on;

  knomial_broadcast_scheduler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kbs_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Command receiver: random stalls per transfer, one long hold-off to back up the input.
  int  stall_left;
  bit  held;
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      held       = 1'b0;
    end else begin
      if (out_valid && out_ready) stall_left = gaps_on ? $urandom_range(0, 11) : 0;
      if (!held && n_accepted >= 40) begin
        held       = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Switch between gappy and back-to-back stretches.
  always @(posedge clk) begin
    if (cycles % 97 == 0) gaps_on <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(logic op, logic [RANK_W-1:0] root, logic [DATA_W-1:0] len,
                           logic [DATA_W-1:0] tag);
    int gap;
    in_item_t it;
    logic taken;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    it.op         = op;
    it.root_rank  = root;
    it.msg_length = len;
    it.msg_tag    = tag;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    // Sample ready mid-cycle so the accepting edge is seen without racing the block.
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    n_accepted++;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain outstanding commands, let the block settle, then reprogram it.
  task automatic configure(int rank, int gsize, int rdx);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    apb_write(REG_MY_RANK, DATA_W'(rank));
    apb_write(REG_N_RANKS, DATA_W'(gsize));
    apb_write(REG_RADIX, DATA_W'(rdx));
  endtask

  // One broadcast: a start and a number of completions.
  task automatic bcast(int root, int n_compl, logic [DATA_W-1:0] len, logic [DATA_W-1:0] tag);
    send_item(OP_BEGIN, RANK_W'(root), len, tag);
    repeat (n_compl) send_item(OP_COMPL, RANK_W'($urandom), $urandom, $urandom);
  endtask

  initial begin
    int gsize, rdx, phase_items, k, pick;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    n_accepted = 0;
    n_random   = 0;
    cycles     = 0;
    gaps_on    = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: group of one completes at once; completion while idle
    bcast(0, 1, 32'h0, 32'hFFFF_FFFF);
    configure(5, 16, 4);
    bcast(0, 3, 32'hFFFF_FFFF, 32'h0);
    bcast(1023, 1, $urandom, $urandom);
    bcast(5, 2, $urandom, $urandom);
    configure(1023, 1024, 31);
    bcast(0, 12, $urandom, $urandom);
    configure(0, 1024, 2);
    bcast(1023, 11, $urandom, $urandom);
    configure(7, 0, 0);
    bcast(3, 1, $urandom, $urandom);
    configure(300, 2047, 1);
    bcast(512, 11, $urandom, $urandom);
    configure(2, 3, 16);
    bcast(1, 2, $urandom, $urandom);

    while (n_random < 200) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      gsize = $urandom_range(2, 40);
      else if (pick < 15) gsize = $urandom_range(41, 1024);
      else if (pick < 17) gsize = 1;
      else                gsize = $urandom_range(0, 2047);
      rdx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      configure($urandom_range(0, 1023), gsize, rdx);
      phase_items = 0;
      while (phase_items < 30) begin
        k = $urandom_range(0, 11);
        bcast($urandom_range(0, 1023), k, $urandom, $urandom);
        phase_items += k + 1;
        // stray completions, mostly ignored
        if ($urandom_range(0, 5) == 0) send_item(OP_COMPL, RANK_W'($urandom), $urandom, $urandom);
      end
      n_random += phase_items;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/kbs_pkg.sv
sv/kbs_div.sv
sv/kbs_datapath.sv
sv/kbs_ctrl.sv
sv/knomial_broadcast_scheduler.sv
test/kbs_checker.sv
test/tb.sv
